FILE: rtl/core/pfa_pkg.sv
// Package for the page frame allocator: request and response payload types,
// status and register codes, fixed field widths and parameter defaults.
// No dependencies.
package pfa_pkg;

  localparam int PFA_STACK_DEPTH = 4096;
  localparam int PFA_PAGE_SHIFT  = 12;
  localparam int PFA_ADDR_BITS   = 32;

  localparam int FRAME_W    = 20;
  localparam int CNT_W      = 21;
  localparam int ADDR_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CNT_W-1:0] COUNT_MAX = 21'h100000;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_MEMORY = 2'd1;
  localparam logic [1:0] ST_BAD_ADDR  = 2'd2;
  localparam logic [1:0] ST_STACK_FULL = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_POOL_START = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POOL_END   = 2'd1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] free_addr;
  } req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] frame_addr;
    logic [1:0]        status;
    logic [CNT_W-1:0]  allocated_count;
    logic [CNT_W-1:0]  free_estimate;
  } rsp_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

endpackage

FILE: rtl/core/pfa_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module pfa_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: rtl/core/page_frame_allocator.sv
// Page frame allocator top level: free-frame stack in pfa_ram, bump cursor
// and frame counters in registers. Depends on pfa_pkg and pfa_ram.
//
// Usage. Requests arrive on req (req_valid, req_stall); a transfer takes
// place on a rising edge with req_valid high and req_stall low. Each
// request gives exactly one response on rsp (rsp_valid, rsp_stall), in
// order. An allocate pops the most recently freed frame or bumps the
// cursor through the pool; a free validates the address and pushes it.
// The request and the stack memory read are registered on the transfer
// edge; the execute state consumes the read data and registers the
// response. No new request is taken until the execute state completes.
// A request is taken while an earlier response still waits; a stalled
// response holds and the following request waits in the execute cycle
// until the response register frees up.
// Configuration: cfg_index 0 writes the pool start frame, 1 the pool end
// frame; either write restarts the pool (cursor to start, stack and
// allocated count cleared, estimate recomputed). Other indexes are
// ignored. Reset (rst, synchronous) gives an empty pool at frame 0; the
// stack memory needs no clearing pass.
module page_frame_allocator
  import pfa_pkg::*;
#(
  parameter int STACK_DEPTH = PFA_STACK_DEPTH,
  parameter int PAGE_SHIFT  = PFA_PAGE_SHIFT,
  parameter int ADDR_BITS   = PFA_ADDR_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  req_t                  req,
  output logic                  rsp_valid,
  input  logic                  rsp_stall,
  output rsp_t                  rsp,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W   = $clog2(STACK_DEPTH);
  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam logic [DEPTH_W-1:0] DEPTH_FULL = DEPTH_W'(STACK_DEPTH);
  localparam logic [39:0] FRAME_SPAN = 40'd1 << (ADDR_BITS - PAGE_SHIFT);
  localparam logic [ADDR_W-1:0] PAGE_MASK = (32'd1 << PAGE_SHIFT) - 32'd1;

  function automatic logic [CNT_W-1:0] clamp_end(input logic [CNT_W-1:0] e);
    clamp_end = ({19'd0, e} > FRAME_SPAN) ? FRAME_SPAN[CNT_W-1:0] : e;
  endfunction

  state_t             state;
  req_t               req_q;
  logic [FRAME_W-1:0] start_frame;
  logic [CNT_W-1:0]   end_frame;
  logic [CNT_W-1:0]   cursor;
  logic [DEPTH_W-1:0] depth;
  logic [CNT_W-1:0]   alloc_cnt;
  logic [CNT_W-1:0]   estimate;

  logic               req_fire;
  logic               rd_en;
  logic [DEPTH_W-1:0] depth_m1;
  logic [FRAME_W-1:0] rd_data;
  logic               complete;

  logic               addr_bad;
  logic [63:0]        addr_ext;
  logic [51:0]        addr_sh;
  logic [FRAME_W-1:0] frame_in;
  logic [CNT_W-1:0]   end_lim;
  logic               do_pop;
  logic               do_bump;
  logic               do_push;
  logic [1:0]         status;
  logic [CNT_W-1:0]   out_frame;
  logic [39:0]        addr_wide;
  logic [CNT_W-1:0]   alloc_cnt_next;
  logic [CNT_W-1:0]   estimate_next;

  logic               cfg_fire;
  logic [FRAME_W-1:0] start_next;
  logic [CNT_W-1:0]   end_next;
  logic [CNT_W-1:0]   lim_next;
  logic [CNT_W-1:0]   restart_est;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign depth_m1  = depth - 1'b1;
  assign rd_en     = req_fire && (req.req_type == REQ_ALLOC) && (depth != '0);
  assign complete  = (state == S_EXEC) && (!rsp_valid || !rsp_stall);

  pfa_ram #(
    .WIDTH (FRAME_W),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk     (clk),
    .wr_en   (complete && do_push),
    .wr_addr (depth[IDX_W-1:0]),
    .wr_data (frame_in),
    .rd_en   (rd_en),
    .rd_addr (depth_m1[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  always_comb begin
    end_lim  = clamp_end(end_frame);
    addr_ext = {32'd0, req_q.free_addr};
    addr_sh  = {20'd0, req_q.free_addr} >> PAGE_SHIFT;
    frame_in = addr_sh[FRAME_W-1:0];
    addr_bad = (req_q.free_addr == '0) || ((req_q.free_addr & PAGE_MASK) != '0) ||
               ((addr_ext >> ADDR_BITS) != 64'd0);
    do_pop    = 1'b0;
    do_bump   = 1'b0;
    do_push   = 1'b0;
    status    = ST_OK;
    out_frame = '0;
    if (req_q.req_type == REQ_ALLOC) begin
      if (depth != '0) begin
        do_pop    = 1'b1;
        out_frame = {1'b0, rd_data};
      end else if (cursor >= end_lim) begin
        status = ST_NO_MEMORY;
      end else begin
        do_bump   = 1'b1;
        out_frame = cursor;
      end
    end else begin
      if (addr_bad) begin
        status = ST_BAD_ADDR;
      end else if (depth >= DEPTH_FULL) begin
        status = ST_STACK_FULL;
      end else begin
        do_push = 1'b1;
      end
    end
    addr_wide = {19'd0, out_frame} << PAGE_SHIFT;

    alloc_cnt_next = alloc_cnt;
    estimate_next  = estimate;
    if (do_pop || do_bump) begin
      if (alloc_cnt < COUNT_MAX) begin
        alloc_cnt_next = alloc_cnt + 1'b1;
      end
      if (estimate != '0) begin
        estimate_next = estimate - 1'b1;
      end
    end else if (do_push) begin
      if (alloc_cnt != '0) begin
        alloc_cnt_next = alloc_cnt - 1'b1;
      end
      if (estimate < COUNT_MAX) begin
        estimate_next = estimate + 1'b1;
      end
    end
  end

  always_comb begin
    cfg_fire   = 1'b0;
    start_next = start_frame;
    end_next   = end_frame;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_POOL_START: begin
          cfg_fire   = 1'b1;
          start_next = cfg_data[FRAME_W-1:0];
        end
        REG_POOL_END: begin
          cfg_fire = 1'b1;
          end_next = cfg_data;
        end
        default: begin
          cfg_fire = 1'b0;
        end
      endcase
    end
    lim_next    = clamp_end(end_next);
    restart_est = (lim_next > {1'b0, start_next}) ? (lim_next - {1'b0, start_next}) : '0;
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_q <= req;
    end
    if (complete) begin
      rsp.frame_addr      <= addr_wide[ADDR_W-1:0];
      rsp.status          <= status;
      rsp.allocated_count <= alloc_cnt_next;
      rsp.free_estimate   <= estimate_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      rsp_valid   <= 1'b0;
      start_frame <= '0;
      end_frame   <= '0;
      cursor      <= '0;
      depth       <= '0;
      alloc_cnt   <= '0;
      estimate    <= '0;
    end else begin
      if (complete) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (complete) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (complete) begin
        alloc_cnt <= alloc_cnt_next;
        estimate  <= estimate_next;
        if (do_pop) begin
          depth <= depth_m1;
        end else if (do_push) begin
          depth <= depth + 1'b1;
        end
        if (do_bump) begin
          cursor <= cursor + 1'b1;
        end
      end
      if (cfg_fire) begin
        start_frame <= start_next;
        end_frame   <= end_next;
        cursor      <= {1'b0, start_next};
        depth       <= '0;
        alloc_cnt   <= '0;
        estimate    <= restart_est;
      end
    end
  end

  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_FULL)
    else $error("free stack depth beyond its capacity");

  a_cursor_bound: assert property (@(posedge clk) disable iff (rst)
    (cursor == {1'b0, start_frame}) || (cursor <= end_lim))
    else $error("bump cursor beyond the pool end");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (alloc_cnt <= COUNT_MAX) && (estimate <= COUNT_MAX))
    else $error("frame counters beyond saturation");

  a_exec_once: assert property (@(posedge clk) disable iff (rst)
    (state == S_EXEC) && complete |=> (state == S_IDLE) && rsp_valid)
    else $error("execute cycle did not deliver a response");

endmodule

FILE: tb/page_frame_allocator_test.sv
// Self-checking testbench for page_frame_allocator: a directed table, random pool phases
// and a short small-pool phase, checked against a behavioural allocator model kept here.
// Depends on pfa_pkg and the page_frame_allocator RTL.
module page_frame_allocator_test;
  import pfa_pkg::*;

  localparam int          WATCHDOG_CYCLES = 4000;
  localparam int          LONG_HOLD       = 250;
  localparam int          PHASES          = 9;
  localparam int          PHASE_ITEMS     = 85;
  localparam int unsigned FRAME_CAP       = 32'd1 << (PFA_ADDR_BITS - PFA_PAGE_SHIFT);
  localparam int unsigned CNT_TOP         = 32'(COUNT_MAX);

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_3 = 2'd3;

  localparam req_t NO_REQ = '0;
  localparam rsp_t NO_RSP = '0;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  reg_idx;
    logic [CFG_DATA_W-1:0] reg_val;
    req_t                  r;
    bit                    typed;
    rsp_t                  want;
  } plan_row_t;

  localparam int NDIR = 28;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  req_t                  req = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  rsp_t                  rsp;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned        cfg_start;
  int unsigned        cfg_end;
  logic [FRAME_W-1:0] freed_stack [PFA_STACK_DEPTH];
  int unsigned        stack_fill;
  int unsigned        cursor;
  int unsigned        alloc_frames;
  int unsigned        est_frames;

  rsp_t        awaited_rsps [$];
  logic [31:0] handed_out [$];
  int          errors = 0;
  bit          no_idle = 1'b0;
  bit          long_hold_due = 1'b0;
  int          quiet = 0;

  // Expected values are typed in only where they can be read off at a glance.
  plan_row_t plan [NDIR] = '{
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'h0, ST_NO_MEMORY, 21'd0, 21'd0}},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'h0}, 1'b1, '{32'h0, ST_BAD_ADDR, 21'd0, 21'd0}},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'h0000_0801}, 1'b1,
      '{32'h0, ST_BAD_ADDR, 21'd0, 21'd0}},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'hFFFF_F000}, 1'b1, '{32'h0, ST_OK, 21'd0, 21'd1}},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'hFFFF_F000, ST_OK, 21'd1, 21'd0}},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'hFFFF_FFFF}, 1'b1,
      '{32'h0, ST_BAD_ADDR, 21'd1, 21'd0}},
    '{ROW_CFG, REG_POOL_START, 21'd0, NO_REQ, 1'b0, NO_RSP},
    '{ROW_CFG, REG_POOL_END, 21'd3, NO_REQ, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'h0, ST_OK, 21'd1, 21'd2}},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'hFFFF_FFFF}, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'h0, ST_NO_MEMORY, 21'd3, 21'd0}},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'h0000_1000}, 1'b0, NO_RSP},
    '{ROW_CFG, REG_POOL_END, 21'h1F_FFFF, NO_REQ, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'h0000_2000}, 1'b1, '{32'h0, ST_OK, 21'd0, COUNT_MAX}},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b0, NO_RSP},
    '{ROW_CFG, REG_POOL_START, 21'h0F_FFFF, NO_REQ, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'hFFFF_F000, ST_OK, 21'd1, 21'd0}},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'h0, ST_NO_MEMORY, 21'd1, 21'd0}},
    '{ROW_CFG, REG_POOL_END, 21'd5, NO_REQ, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b1, '{32'h0, ST_NO_MEMORY, 21'd0, 21'd0}},
    '{ROW_CFG, REG_UNUSED_2, 21'h1F_FFFF, NO_REQ, 1'b0, NO_RSP},
    '{ROW_CFG, REG_UNUSED_3, 21'h0A_AAAA, NO_REQ, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_FREE, 32'h8000_0000}, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h0}, 1'b0, NO_RSP},
    '{ROW_CFG, REG_POOL_START, 21'h10_0003, NO_REQ, 1'b0, NO_RSP},
    '{ROW_REQ, '0, '0, '{REQ_ALLOC, 32'h5555_5555}, 1'b0, NO_RSP}
  };

  page_frame_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned usable_end();
    return (cfg_end > FRAME_CAP) ? FRAME_CAP : cfg_end;
  endfunction

  function automatic void rebuild_pool();
    int unsigned top;
    top = usable_end();
    cursor       = cfg_start;
    stack_fill   = 0;
    alloc_frames = 0;
    if (top > cfg_start) begin
      est_frames = (top - cfg_start > CNT_TOP) ? CNT_TOP : top - cfg_start;
    end else begin
      est_frames = 0;
    end
  endfunction

  function automatic void take_frame();
    if (alloc_frames < CNT_TOP) alloc_frames++;
    if (est_frames > 0) est_frames--;
  endfunction

  function automatic rsp_t frame_answer(req_t r);
    rsp_t a;
    a = '0;
    if (r.req_type == REQ_ALLOC) begin
      if (stack_fill > 0) begin
        stack_fill--;
        a.frame_addr = ADDR_W'(freed_stack[stack_fill]) << PFA_PAGE_SHIFT;
        take_frame();
      end else if (cursor >= usable_end()) begin
        a.status = ST_NO_MEMORY;
      end else begin
        a.frame_addr = ADDR_W'(cursor << PFA_PAGE_SHIFT);
        cursor++;
        take_frame();
      end
    end else begin
      if (r.free_addr == '0 || r.free_addr[PFA_PAGE_SHIFT-1:0] != '0 ||
          (64'(r.free_addr) >> PFA_ADDR_BITS) != 0) begin
        a.status = ST_BAD_ADDR;
      end else if (stack_fill >= PFA_STACK_DEPTH) begin
        a.status = ST_STACK_FULL;
      end else begin
        freed_stack[stack_fill] = FRAME_W'(r.free_addr >> PFA_PAGE_SHIFT);
        stack_fill++;
        if (alloc_frames > 0) alloc_frames--;
        if (est_frames < CNT_TOP) est_frames++;
      end
    end
    a.allocated_count = CNT_W'(alloc_frames);
    a.free_estimate   = CNT_W'(est_frames);
    return a;
  endfunction

  task automatic issue_request(input req_t r, input bit typed, input rsp_t typed_rsp,
                               output rsp_t predicted);
    if (cfg_valid) cfg_valid <= 1'b0;
    while (!no_idle && $urandom_range(99) < 34) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (req_stall);
    predicted = frame_answer(r);
    awaited_rsps.push_back(typed ? typed_rsp : predicted);
  endtask

  task automatic quiesce();
    if (req_valid) req_valid <= 1'b0;
    while (awaited_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    quiesce();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_POOL_START) begin
      cfg_start = val[FRAME_W-1:0];
      rebuild_pool();
    end else if (idx == REG_POOL_END) begin
      cfg_end = val;
      rebuild_pool();
    end
  endtask

  task automatic field_check(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  initial begin : rsp_side
    int   hold_left;
    rsp_t want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid && !rsp_stall) begin
        if (awaited_rsps.size() == 0) begin
          $display("%0t: unexpected response, expected none, actual %h", $time, rsp);
          errors++;
        end else begin
          want = awaited_rsps.pop_front();
          field_check("frame_addr", want.frame_addr, rsp.frame_addr);
          field_check("status", 32'(want.status), 32'(rsp.status));
          field_check("allocated_count", 32'(want.allocated_count),
                      32'(rsp.allocated_count));
          field_check("free_estimate", 32'(want.free_estimate), 32'(rsp.free_estimate));
        end
      end
      if (long_hold_due) begin
        long_hold_due = 1'b0;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= !no_idle && ($urandom_range(99) < 34);
      end
    end
  end

  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= WATCHDOG_CYCLES) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : req_side
    req_t                  r;
    rsp_t                  got;
    int                    pick;
    int unsigned           frame;
    int unsigned           start;
    int unsigned           pool_top;
    bit                    end_first;
    logic [CFG_IDX_W-1:0]  spare_idx;

    cfg_start = 0;
    cfg_end   = 0;
    rebuild_pool();
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NDIR; i++) begin
      if (plan[i].kind == ROW_CFG) begin
        write_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        issue_request(plan[i].r, plan[i].typed, plan[i].want, got);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      start = $urandom_range(FRAME_CAP - 1);
      case ($urandom_range(9))
        6: pool_top = $urandom() & 32'h1F_FFFF;
        7: begin
          start = 0;
          pool_top = $urandom_range(1, 40);
        end
        8: pool_top = 32'h1F_FFFF;
        9: pool_top = (start > 8) ? start - $urandom_range(1, 8) : 0;
        default: pool_top = start + $urandom_range(0, 60);
      endcase
      end_first = $urandom_range(1);
      if (end_first) write_reg(REG_POOL_END, CFG_DATA_W'(pool_top));
      write_reg(REG_POOL_START, {1'($urandom_range(1)), FRAME_W'(start)});
      if (!end_first) write_reg(REG_POOL_END, CFG_DATA_W'(pool_top));
      if ($urandom_range(4) == 0) begin
        spare_idx = $urandom_range(1) ? REG_UNUSED_2 : REG_UNUSED_3;
        write_reg(spare_idx, CFG_DATA_W'($urandom()));
      end
      handed_out.delete();
      no_idle = (ph == 3);
      if (ph == 1) long_hold_due = 1'b1;

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 2 && n == PHASE_ITEMS / 2) quiesce();
        pick = $urandom_range(99);
        r.free_addr = $urandom();
        if (pick < 50) begin
          r.req_type = REQ_ALLOC;
        end else begin
          r.req_type = REQ_FREE;
          if (pick < 80 && handed_out.size() > 0) begin
            pick = $urandom_range(handed_out.size() - 1);
            r.free_addr = handed_out[pick];
            handed_out.delete(pick);
          end else if (pick < 88) begin
            frame = $urandom_range(FRAME_CAP - 1);
            r.free_addr = ADDR_W'(frame << PFA_PAGE_SHIFT);
          end else if (pick < 92) begin
            r.free_addr = '0;
          end else if (pick < 97) begin
            r.free_addr = r.free_addr | (32'd1 << $urandom_range(PFA_PAGE_SHIFT - 1));
          end
        end
        issue_request(r, 1'b0, NO_RSP, got);
        if (r.req_type == REQ_ALLOC && got.status == ST_OK) handed_out.push_back(got.frame_addr);
      end
    end
    no_idle = 1'b0;

    // A pool of a few frames with mixed traffic closes the run.
    start = $urandom_range(1, 1000);
    write_reg(REG_POOL_START, CFG_DATA_W'(start));
    write_reg(REG_POOL_END, CFG_DATA_W'(start + 4));
    for (int n = 0; n < 60; n++) begin
      frame = $urandom_range(1, FRAME_CAP - 1);
      r.req_type  = $urandom_range(1) ? REQ_FREE : REQ_ALLOC;
      r.free_addr = ADDR_W'(frame << PFA_PAGE_SHIFT);
      issue_request(r, 1'b0, NO_RSP, got);
    end

    quiesce();
    if (cfg_valid) cfg_valid <= 1'b0;
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
